### design/segment_triangle_intersect_macros.svh
// ----------------------------------------------------------------------------
// Segment/triangle intersection: assertion macros
// Shared concurrent assertion forms, clocked on aclk; the same-cycle form is quiet during reset.
// ----------------------------------------------------------------------------
`ifndef SEGMENT_TRIANGLE_INTERSECT_MACROS_SVH
`define SEGMENT_TRIANGLE_INTERSECT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define STI_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("segment_triangle_intersect: assertion failed");

// Next-cycle implication, checked during reset as well.
`define STI_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error("segment_triangle_intersect: assertion failed");

`endif

### design/sti_pkg.sv
// ----------------------------------------------------------------------------
// Segment/triangle intersection package
// Default sizes, register indexes and the divider control bundle.
// ----------------------------------------------------------------------------
package sti_pkg;

    localparam int COORD_WIDTH_DEF    = 16;
    localparam int TIME_FRAC_BITS_DEF = 16;
    localparam int CFG_ADDR_W         = 3;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_START_X = 3'd0,
        REG_START_Y = 3'd1,
        REG_START_Z = 3'd2,
        REG_END_X   = 3'd3,
        REG_END_Y   = 3'd4,
        REG_END_Z   = 3'd5
    } seg_reg_t;

    typedef struct packed {
        logic valid;
        logic hit;
        logic eq;
    } div_ctl_t;

endpackage

### design/segment_triangle_intersect.sv
// ----------------------------------------------------------------------------
// Segment/triangle intersection
// One-sided test of a configured segment against one streamed triangle.
// ----------------------------------------------------------------------------
// The segment from P (seg_start) to Q (seg_end) is loaded through the write
// port; the user is to load it only while the block is idle, which the block
// does not enforce. Each triangle transfer yields exactly one result transfer
// carrying a hit flag and the hit time t = num/d as an unsigned fraction with
// TIME_FRAC_BITS bits, where 1.0 is one above the top fraction bit. A triangle
// may be accepted in every cycle while the output is not stalled. Six arithmetic
// stages (differences, cross-product terms, cross products, dot-product terms,
// sums, bound checks) are followed by a restoring divider that produces one
// quotient bit per stage. The whole pipeline advances whenever the output
// register is empty or being taken, so a stalled result holds every stage in place.
// ----------------------------------------------------------------------------
`include "segment_triangle_intersect_macros.svh"

module segment_triangle_intersect #(
    parameter int COORD_WIDTH    = sti_pkg::COORD_WIDTH_DEF,
    parameter int TIME_FRAC_BITS = sti_pkg::TIME_FRAC_BITS_DEF,
    localparam int IN_W  = ((9 * COORD_WIDTH + 7) / 8) * 8,
    localparam int OUT_W = ((TIME_FRAC_BITS + 2 + 7) / 8) * 8
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [sti_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [COORD_WIDTH-1:0]          cfg_wdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // vert_a_x, vert_a_y, vert_a_z, vert_b_x, vert_b_y, vert_b_z,
    // vert_c_x, vert_c_y, vert_c_z, zero padding
    input  logic [IN_W-1:0]                 s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // hit, hit_time, zero padding
    output logic [OUT_W-1:0]                m_tdata
);
    import sti_pkg::*;

    localparam int CW     = COORD_WIDTH;
    localparam int DIF_W  = CW + 1;
    localparam int PRC_W  = 2 * DIF_W;
    localparam int CRS_W  = PRC_W + 1;
    localparam int PRD_W  = DIF_W + CRS_W;
    localparam int DOT_W  = PRD_W + 2;

    // Segment registers.
    logic signed [CW-1:0] p_reg [3];
    logic signed [CW-1:0] q_reg [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < 3; k++) begin
                p_reg[k] <= '0;
                q_reg[k] <= '0;
            end
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_START_X: p_reg[0] <= cfg_wdata;
                REG_START_Y: p_reg[1] <= cfg_wdata;
                REG_START_Z: p_reg[2] <= cfg_wdata;
                REG_END_X:   q_reg[0] <= cfg_wdata;
                REG_END_Y:   q_reg[1] <= cfg_wdata;
                REG_END_Z:   q_reg[2] <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // The pipeline moves as one whenever the output register can be refilled.
    logic en;
    div_ctl_t div_ctl_out;
    assign en       = !div_ctl_out.valid || m_tready;
    assign s_tready = en;

    logic signed [CW-1:0] va [3];
    logic signed [CW-1:0] vb [3];
    logic signed [CW-1:0] vc [3];
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            va[k] = s_tdata[k * CW +: CW];
            vb[k] = s_tdata[(3 + k) * CW +: CW];
            vc[k] = s_tdata[(6 + k) * CW +: CW];
        end
    end

    // Stage valid bits.
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    // Stage 1: edge vectors B-A, C-A, the reversed segment P-Q and P-A.
    logic signed [DIF_W-1:0] ab1_reg [3], ac1_reg [3], qp1_reg [3], ap1_reg [3];
    // Stage 2: cross-product terms, with the difference vectors carried along.
    logic signed [PRC_W-1:0] na2_reg [3], nb2_reg [3], ea2_reg [3], eb2_reg [3];
    logic signed [DIF_W-1:0] ab2_reg [3], ac2_reg [3], qp2_reg [3], ap2_reg [3];
    // Stage 3: normal N and E = QP x AP.
    logic signed [CRS_W-1:0] n3_reg [3], e3_reg [3];
    logic signed [DIF_W-1:0] ab3_reg [3], ac3_reg [3], qp3_reg [3], ap3_reg [3];
    // Stage 4: dot-product terms.
    logic signed [PRD_W-1:0] pd4_reg [3], pn4_reg [3], pv4_reg [3], pw4_reg [3];
    // Stage 5: d, num, v and w.
    logic signed [DOT_W-1:0] d5_reg, num5_reg, v5s_reg, w5_reg;
    // Stage 6: bound checks reduced to a hit flag.
    logic                    hit6_reg, eq6_reg;
    logic [DOT_W-1:0]        num6_reg, d6_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                ab1_reg[k] <= DIF_W'(vb[k]) - DIF_W'(va[k]);
                ac1_reg[k] <= DIF_W'(vc[k]) - DIF_W'(va[k]);
                qp1_reg[k] <= DIF_W'(p_reg[k]) - DIF_W'(q_reg[k]);
                ap1_reg[k] <= DIF_W'(p_reg[k]) - DIF_W'(va[k]);

                na2_reg[k] <= ab1_reg[(k + 1) % 3] * ac1_reg[(k + 2) % 3];
                nb2_reg[k] <= ab1_reg[(k + 2) % 3] * ac1_reg[(k + 1) % 3];
                ea2_reg[k] <= qp1_reg[(k + 1) % 3] * ap1_reg[(k + 2) % 3];
                eb2_reg[k] <= qp1_reg[(k + 2) % 3] * ap1_reg[(k + 1) % 3];
                ab2_reg[k] <= ab1_reg[k];
                ac2_reg[k] <= ac1_reg[k];
                qp2_reg[k] <= qp1_reg[k];
                ap2_reg[k] <= ap1_reg[k];

                n3_reg[k]  <= CRS_W'(na2_reg[k]) - CRS_W'(nb2_reg[k]);
                e3_reg[k]  <= CRS_W'(ea2_reg[k]) - CRS_W'(eb2_reg[k]);
                ab3_reg[k] <= ab2_reg[k];
                ac3_reg[k] <= ac2_reg[k];
                qp3_reg[k] <= qp2_reg[k];
                ap3_reg[k] <= ap2_reg[k];

                pd4_reg[k] <= qp3_reg[k] * n3_reg[k];
                pn4_reg[k] <= ap3_reg[k] * n3_reg[k];
                pv4_reg[k] <= ac3_reg[k] * e3_reg[k];
                pw4_reg[k] <= ab3_reg[k] * e3_reg[k];
            end

            d5_reg   <= DOT_W'(pd4_reg[0]) + DOT_W'(pd4_reg[1]) + DOT_W'(pd4_reg[2]);
            num5_reg <= DOT_W'(pn4_reg[0]) + DOT_W'(pn4_reg[1]) + DOT_W'(pn4_reg[2]);
            v5s_reg  <= DOT_W'(pv4_reg[0]) + DOT_W'(pv4_reg[1]) + DOT_W'(pv4_reg[2]);
            w5_reg   <= -(DOT_W'(pw4_reg[0]) + DOT_W'(pw4_reg[1]) + DOT_W'(pw4_reg[2]));

            // Front-facing, plane crossed within the segment, inside the triangle.
            hit6_reg <= (d5_reg > 0) && !num5_reg[DOT_W-1] && (num5_reg <= d5_reg)
                        && !v5s_reg[DOT_W-1] && (v5s_reg <= d5_reg) && !w5_reg[DOT_W-1]
                        && ((v5s_reg + w5_reg) <= d5_reg);
            eq6_reg  <= num5_reg == d5_reg;
            num6_reg <= num5_reg;
            d6_reg   <= d5_reg;
        end
    end

    div_ctl_t             div_ctl_in;
    logic [TIME_FRAC_BITS:0] hit_time;
    assign div_ctl_in = '{valid: v6_reg, hit: hit6_reg, eq: eq6_reg};

    sti_div_pipe #(
        .DW  (DOT_W),
        .TFB (TIME_FRAC_BITS)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .ctl_in   (div_ctl_in),
        .num_in   (num6_reg),
        .den_in   (d6_reg),
        .ctl_out  (div_ctl_out),
        .time_out (hit_time)
    );

    // The divider's last stage is the output register.
    assign m_tvalid = div_ctl_out.valid;
    assign m_tdata  = OUT_W'({hit_time, div_ctl_out.hit});

    `STI_ASSERT_IMP(a_time_bounded, m_tvalid, hit_time <= {1'b1, {TIME_FRAC_BITS{1'b0}}})
    `STI_ASSERT_IMP(a_miss_zero, m_tvalid && !div_ctl_out.hit, hit_time == '0)
    `STI_ASSERT_NEXT(a_reset_empties, !aresetn, !m_tvalid)

endmodule

### design/sti_div_pipe.sv
// ----------------------------------------------------------------------------
// Segment/triangle intersection: pipelined restoring divider
// One quotient bit per stage; the last stage applies the miss and 1.0 cases.
// ----------------------------------------------------------------------------
module sti_div_pipe #(
    parameter int DW  = 54,
    parameter int TFB = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  sti_pkg::div_ctl_t     ctl_in,
    input  logic [DW-1:0]         num_in,
    input  logic [DW-1:0]         den_in,
    output sti_pkg::div_ctl_t     ctl_out,
    output logic [TFB:0]          time_out
);
    import sti_pkg::*;

    div_ctl_t         ctl_reg [TFB];
    logic [DW:0]      rem_reg [TFB];
    logic [DW-1:0]    den_reg [TFB];
    logic [TFB:0]     q_reg   [TFB];

    for (genvar j = 0; j < TFB; j++) begin : g_step
        div_ctl_t      ctl_src;
        logic [DW:0]   rem_src;
        logic [DW-1:0] den_src;
        logic [TFB:0]  q_src;
        logic [DW:0]   shifted;
        logic          ge;
        logic [DW:0]   rem_next;
        logic [TFB:0]  q_next;

        if (j == 0) begin : g_first
            assign ctl_src = ctl_in;
            assign rem_src = {1'b0, num_in};
            assign den_src = den_in;
            assign q_src   = '0;
        end else begin : g_rest
            assign ctl_src = ctl_reg[j-1];
            assign rem_src = rem_reg[j-1];
            assign den_src = den_reg[j-1];
            assign q_src   = q_reg[j-1];
        end

        assign shifted  = {rem_src[DW-1:0], 1'b0};
        assign ge       = shifted >= {1'b0, den_src};
        assign rem_next = ge ? (shifted - {1'b0, den_src}) : shifted;

        if (j == TFB - 1) begin : g_last
            // Misses report zero; num equal to d reports exactly 1.0.
            always_comb begin
                q_next = {q_src[TFB-1:0], ge};
                if (!ctl_src.hit) begin
                    q_next = '0;
                end else if (ctl_src.eq) begin
                    q_next = {1'b1, {TFB{1'b0}}};
                end
            end
        end else begin : g_mid
            assign q_next = {q_src[TFB-1:0], ge};
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                ctl_reg[j].valid <= 1'b0;
            end else if (en) begin
                ctl_reg[j] <= ctl_src;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[j] <= rem_next;
                den_reg[j] <= den_src;
                q_reg[j]   <= q_next;
            end
        end
    end

    assign ctl_out  = ctl_reg[TFB-1];
    assign time_out = q_reg[TFB-1];

endmodule

### tb/tb_segment_triangle_intersect.sv
// ----------------------------------------------------------------------------
// Segment/triangle intersection testbench
// Streams triangles against several configured segments and compares every
// result transfer with an exact, wide-arithmetic prediction of hit and time.
// ----------------------------------------------------------------------------
module tb_segment_triangle_intersect;
    import sti_pkg::*;

    localparam int CW    = 16;
    localparam int FB    = 16;
    localparam int IN_W  = ((9 * CW + 7) / 8) * 8;
    localparam int OUT_W = ((FB + 2 + 7) / 8) * 8;
    localparam int LATENCY = 6 + FB;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic        hit;
        logic [16:0] hit_time;
    } isect_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CW-1:0] cfg_wdata = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [IN_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;

    // Segment endpoints as the testbench believes the block holds them.
    logic signed [CW-1:0] seg_p [3];
    logic signed [CW-1:0] seg_q [3];

    isect_t expected_isects [$];
    int     error_count = 0;
    longint cycle_count = 0;
    bit     hold_off = 1'b0;
    bit     quiet_sink = 1'b0;

    segment_triangle_intersect DUT (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // The run is ended here, as a mismatch, once the cycle count passes CYCLE_LIMIT.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("segment_triangle_intersect: mismatch");
            $finish;
        end
    end

    task automatic report(input string what);
        $display("ERROR at cycle %0d: %s", cycle_count, what);
        error_count++;
    endtask

    // Exact intersection prediction. Cross products fit in 40 bits and dot
    // sums in 60, so 96-bit signed arithmetic is comfortably exact.
    function automatic isect_t predict_isect(input logic [IN_W-1:0] tri_bits);
        logic signed [95:0] a [3], b [3], c [3], ab [3], ac [3], qp [3], ap [3];
        logic signed [95:0] nrm [3], e [3];
        logic signed [95:0] d, num, v, w, rem;
        isect_t r;
        r = '0;
        for (int i = 0; i < 3; i++) begin
            a[i] = $signed(tri_bits[i*CW +: CW]);
            b[i] = $signed(tri_bits[(3+i)*CW +: CW]);
            c[i] = $signed(tri_bits[(6+i)*CW +: CW]);
            ab[i] = b[i] - a[i];
            ac[i] = c[i] - a[i];
            qp[i] = 96'(seg_p[i]) - 96'(seg_q[i]);
            ap[i] = 96'(seg_p[i]) - a[i];
        end
        nrm[0] = ab[1]*ac[2] - ab[2]*ac[1];
        nrm[1] = ab[2]*ac[0] - ab[0]*ac[2];
        nrm[2] = ab[0]*ac[1] - ab[1]*ac[0];
        d = qp[0]*nrm[0] + qp[1]*nrm[1] + qp[2]*nrm[2];
        if (d <= 0) return r;
        num = ap[0]*nrm[0] + ap[1]*nrm[1] + ap[2]*nrm[2];
        if (num < 0 || num > d) return r;
        e[0] = qp[1]*ap[2] - qp[2]*ap[1];
        e[1] = qp[2]*ap[0] - qp[0]*ap[2];
        e[2] = qp[0]*ap[1] - qp[1]*ap[0];
        v = ac[0]*e[0] + ac[1]*e[1] + ac[2]*e[2];
        if (v < 0 || v > d) return r;
        w = -(ab[0]*e[0] + ab[1]*e[1] + ab[2]*e[2]);
        if (w < 0 || v + w > d) return r;
        r.hit = 1'b1;
        if (num == d) begin
            r.hit_time = 17'h10000;
        end else begin
            rem = num;
            for (int i = 0; i < FB; i++) begin
                rem = rem <<< 1;
                r.hit_time = r.hit_time << 1;
                if (rem >= d) begin
                    rem = rem - d;
                    r.hit_time[0] = 1'b1;
                end
            end
        end
        return r;
    endfunction

    // Result checker: samples at the rising edge and picks up a transfer.
    always @(posedge aclk) begin
        isect_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got.hit = m_tdata[0];
            got.hit_time = m_tdata[17:1];
            if (m_tdata[OUT_W-1:18] != '0) report("padding bits not zero");
            if (expected_isects.size() == 0) begin
                report("result transfer with nothing expected");
            end else begin
                want = expected_isects.pop_front();
                if (got.hit !== want.hit)
                    report($sformatf("hit %b, expected %b", got.hit, want.hit));
                if (got.hit_time !== want.hit_time)
                    report($sformatf("hit_time %0d, expected %0d",
                                     got.hit_time, want.hit_time));
            end
        end
    end

    // Receiver: random stalls, stretches without them, and a long hold-off
    // on request, all changed at the falling edge.
    initial begin
        int gap;
        forever begin
            @(negedge aclk);
            if (hold_off) begin
                m_tready <= 1'b0;
            end else if (quiet_sink) begin
                m_tready <= 1'b1;
            end else begin
                gap = $urandom_range(0, 8);
                if (gap == 0 || $urandom_range(0, 1)) begin
                    m_tready <= 1'b1;
                end else begin
                    m_tready <= 1'b0;
                    repeat (gap - 1) begin
                        @(negedge aclk);
                        if (hold_off) break;
                    end
                end
            end
        end
    end

    // Sends one triangle, after a random gap unless the gaps are off.
    task automatic send_triangle(input logic [IN_W-1:0] tri_bits, input bit no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 8);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= tri_bits;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        expected_isects = {expected_isects, predict_isect(tri_bits)};
        @(negedge aclk);
    endtask

    task automatic end_burst();
        s_tvalid <= 1'b0;
    endtask

    // Waits until every result has arrived, then lets the pipeline drain.
    task automatic wait_idle();
        end_burst();
        while (expected_isects.size() != 0) @(negedge aclk);
        repeat (LATENCY + 4) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CW-1:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we <= 1'b0;
        if (idx <= REG_END_Z) begin
            if (idx < REG_END_X) seg_p[idx] = val;
            else seg_q[idx - REG_END_X] = val;
        end
    endtask

    task automatic set_segment(input logic [CW-1:0] px, py, pz, qx, qy, qz);
        write_reg(REG_START_X, px);
        write_reg(REG_START_Y, py);
        write_reg(REG_START_Z, pz);
        write_reg(REG_END_X, qx);
        write_reg(REG_END_Y, qy);
        write_reg(REG_END_Z, qz);
    endtask

    function automatic logic [IN_W-1:0] pack_tri(input logic [CW-1:0] v [9]);
        logic [IN_W-1:0] t;
        t = '0;
        for (int i = 0; i < 9; i++) t[i*CW +: CW] = v[i];
        return t;
    endfunction

    function automatic logic [CW-1:0] rnd_coord(input int span);
        return CW'($signed($urandom_range(0, 2*span)) - span);
    endfunction

    // A triangle around the segment's z-axis crossing point, facing it,
    // with random size; many of these hit and many graze an edge.
    function automatic logic [IN_W-1:0] facing_tri(input int span);
        logic [CW-1:0] v [9];
        int zc;
        zc = $urandom_range(0, 1600);
        v[0] = rnd_coord(span) - CW'(span); v[1] = rnd_coord(span) - CW'(span);
        v[2] = CW'(zc) + rnd_coord(8);
        v[3] = rnd_coord(span) + CW'(span); v[4] = rnd_coord(span) - CW'(span);
        v[5] = CW'(zc) + rnd_coord(8);
        v[6] = rnd_coord(span);             v[7] = rnd_coord(span) + CW'(span);
        v[8] = CW'(zc) + rnd_coord(8);
        return pack_tri(v);
    endfunction

    function automatic logic [IN_W-1:0] noise_tri();
        logic [IN_W-1:0] t;
        t = '0;
        for (int i = 0; i < 9; i++) t[i*CW +: CW] = CW'($urandom);
        return t;
    endfunction

    // Edges, corners, degenerate shapes, back faces and coordinate extremes.
    task automatic test_directed();
        logic [CW-1:0] v [9];
        // Segment down the z axis from z=1600 to z=0, i.e. facing a CCW triangle.
        set_segment(16'sd0, 16'sd0, 16'sd1600, 16'sd0, 16'sd0, 16'sd0);
        v = '{-16'sd160, -16'sd160, 16'sd800, 16'sd160, -16'sd160, 16'sd800,
              16'sd0, 16'sd160, 16'sd800};
        send_triangle(pack_tri(v), 0);                 // plain hit at half
        v = '{-16'sd160, -16'sd160, 16'sd800, 16'sd0, 16'sd160, 16'sd800,
              16'sd160, -16'sd160, 16'sd800};
        send_triangle(pack_tri(v), 0);                 // back face
        v = '{16'sd0, 16'sd0, 16'sd0, 16'sd160, 16'sd0, 16'sd0,
              16'sd0, 16'sd160, 16'sd0};
        send_triangle(pack_tri(v), 0);                 // vertex at Q, t = 1.0
        v = '{16'sd0, 16'sd0, 16'sd1600, 16'sd160, 16'sd0, 16'sd1600,
              16'sd0, 16'sd160, 16'sd1600};
        send_triangle(pack_tri(v), 0);                 // vertex at P, t = 0
        v = '{-16'sd160, 16'sd0, 16'sd400, 16'sd160, 16'sd0, 16'sd400,
              16'sd0, 16'sd160, 16'sd400};
        send_triangle(pack_tri(v), 0);                 // on an edge
        v = '{16'sd10, 16'sd10, 16'sd400, 16'sd20, 16'sd20, 16'sd400,
              16'sd30, 16'sd30, 16'sd400};
        send_triangle(pack_tri(v), 0);                 // degenerate
        v = '{-16'sd160, -16'sd160, -16'sd10, 16'sd160, -16'sd160, -16'sd10,
              16'sd0, 16'sd160, -16'sd10};
        send_triangle(pack_tri(v), 0);                 // plane beyond Q
        v = '{-16'sd160, -16'sd160, 16'sd1700, 16'sd160, -16'sd160, 16'sd1700,
              16'sd0, 16'sd160, 16'sd1700};
        send_triangle(pack_tri(v), 0);                 // plane before P
        v = '{16'sd100, 16'sd100, 16'sd800, 16'sd300, 16'sd100, 16'sd800,
              16'sd100, 16'sd300, 16'sd800};
        send_triangle(pack_tri(v), 0);                 // off to the side
        v = '{-16'sd32768, -16'sd32768, 16'sd1, 16'sd32767, -16'sd32768, 16'sd1,
              16'sd0, 16'sd32767, 16'sd1};
        send_triangle(pack_tri(v), 0);                 // huge, t just under 1
        for (int i = 0; i < 9; i++) v[i] = 16'h8000;
        send_triangle(pack_tri(v), 0);
        for (int i = 0; i < 9; i++) v[i] = 16'h7fff;
        send_triangle(pack_tri(v), 0);
        send_triangle({IN_W{1'b1}}, 0);
        send_triangle(pack_tri('{16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000,
                                 16'h7fff, 16'h0000, 16'hffff, 16'h8000}), 0);
        wait_idle();
        // Zero-length segment at the extreme corner, and writes to the two ignored indexes.
        set_segment(16'h7fff, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 16'h7fff);
        write_reg(CFG_ADDR_W'(6), 16'h1234);
        write_reg(CFG_ADDR_W'(7), 16'hffff);
        send_triangle(noise_tri(), 0);
        send_triangle(pack_tri('{16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h8000,
                                 16'h8000, 16'h8000, 16'h7fff, 16'h8000}), 0);
        wait_idle();
        // Full-range segment from one corner to the other.
        set_segment(16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h7fff, 16'h8000);
        for (int i = 0; i < 6; i++) send_triangle(noise_tri(), 0);
        wait_idle();
    endtask

    // Random triangles for a series of segments, mostly facing ones.
    task automatic test_random(input int count);
        for (int phase = 0; phase < 5; phase++) begin
            if (phase == 4)
                set_segment(16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h7fff, 16'h8000);
            else
                set_segment(rnd_coord(40), rnd_coord(40), 16'sd1700 + rnd_coord(60),
                            rnd_coord(40), rnd_coord(40), rnd_coord(60));
            quiet_sink = (phase == 1);
            for (int n = 0; n < count / 5; n++) begin
                if ($urandom_range(0, 3) == 0) send_triangle(noise_tri(), phase == 1);
                else send_triangle(facing_tri($urandom_range(1, 2000)), phase == 1);
            end
            wait_idle();
        end
        quiet_sink = 1'b0;
    endtask

    // The receiver holds off for a long stretch while triangles keep coming.
    task automatic test_backpressure();
        fork
            begin
                hold_off = 1'b1;
                repeat (200) @(negedge aclk);
                hold_off = 1'b0;
            end
            for (int n = 0; n < 120; n++)
                send_triangle(facing_tri($urandom_range(1, 400)), 1);
        join
        wait_idle();
    endtask

    initial begin
        for (int i = 0; i < 3; i++) begin
            seg_p[i] = '0;
            seg_q[i] = '0;
        end
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_directed();
        test_random(1000);
        test_backpressure();
        if (error_count == 0) begin
            $display("segment_triangle_intersect: match");
        end else begin
            $display("segment_triangle_intersect: mismatch");
        end
        $finish;
    end
endmodule

### sim.f
+incdir+design
design/sti_pkg.sv
design/sti_div_pipe.sv
design/segment_triangle_intersect.sv
tb/tb_segment_triangle_intersect.sv
